// ===== src/pfx_pkg.sv =====
// Shared constants for the postfix expression evaluator.
// Stack sizing, status codes, character codes and operator codes.
// No dependencies.
package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int DATA_W      = 32;
    localparam int STEP_W      = 5;   // divider step counter, 32 steps

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_LEFTOVER  = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_DIVZERO   = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    // character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

endpackage

// ===== src/postfix_expression_evaluator.sv =====
// Postfix (RPN) expression evaluator: top level.
// Depends on pfx_pkg and pfx_ram (operand stack).
//
// Usage:
//   Slave channel carries one expression character per transaction in
//   tdata[7:0]; tlast high marks the end-of-expression transaction (its
//   tdata is ignored). Master channel returns one transaction per end
//   marker: tdata[31:0] = signed answer (zero on error), tuser[2:0] =
//   status (0 ok, 1 invalid char, 2 underflow, 3 leftover operands,
//   4 empty, 5 divide by zero, 6 overflow).
// Sequencing:
//   Digits, whitespace, invalid characters and any character after an
//   error are handled as they are accepted. + - * run accept, two stack
//   reads through the single RAM read port, then execute and push together.
//   An operator short of operands stops at the operand check, a divide by
//   zero at the execute step. / and % add the restoring divider, one quotient
//   bit per cycle (32 steps), then sign fixup and push. The end marker closes
//   any pending number, reads the bottom entry, then loads the result register.
//   tready is low while an item is in work.
// Reset (synchronous, active low) empties the stack, clears the number
// accumulator and error. The result register holds its transaction while
// the receiver stalls; the block keeps taking characters meanwhile and
// only the next end marker waits for the register to drain.
module postfix_expression_evaluator
    import pfx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // action: end of expression
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] answer
    output logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_OP_RHS    = 4'd1;  // read top of stack
    localparam logic [3:0] S_OP_LHS    = 4'd2;  // read next, latch rhs
    localparam logic [3:0] S_EXEC      = 4'd3;  // add/sub/mul or divider start
    localparam logic [3:0] S_DIV       = 4'd4;  // one quotient bit per cycle
    localparam logic [3:0] S_DIV_DONE  = 4'd5;  // sign fixup, push
    localparam logic [3:0] S_END_CLOSE = 4'd6;  // close pending number
    localparam logic [3:0] S_END_READ  = 4'd7;  // read bottom entry
    localparam logic [3:0] S_END_OUT   = 4'd8;  // load result register

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_in_num, n_in_num;
    logic [2:0]        r_err, n_err;
    logic [2:0]        r_op, n_op;
    logic [DATA_W-1:0] r_rhs, n_rhs;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_neg_q, n_neg_q;
    logic              r_neg_r, n_neg_r;
    logic              r_m_valid, n_m_valid;
    logic [DATA_W-1:0] r_m_data, n_m_data;
    logic [2:0]        r_m_user, n_m_user;

    // stack RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    pfx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // datapath helpers
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              push_req;
    logic [DATA_W-1:0] push_val;
    logic [7:0]        ch;
    logic [DATA_W-1:0] digit_val;
    logic [DATA_W-1:0] lhs_cur;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W-1:0] abs_lhs, abs_rhs;
    logic [DATA_W:0]   rem_sh, rem_diff;
    logic [DATA_W-1:0] quo_s, rem_s;
    logic              accept_in;

    // lhs comes straight off the RAM read issued in S_OP_LHS; valid in S_EXEC
    assign lhs_cur   = ram_rdata;
    assign ch        = i_s_axis_tdata;
    assign accept_in = i_s_axis_tvalid && o_s_axis_tready;
    assign cnt_m1    = r_cnt - 1'b1;
    assign cnt_m2    = r_cnt - 2'd2;
    assign digit_val = {24'd0, ch - CH_0};
    assign mul_lo    = lhs_cur * r_rhs;
    assign abs_lhs   = lhs_cur[DATA_W-1] ? -lhs_cur : lhs_cur;
    assign abs_rhs   = r_rhs[DATA_W-1] ? -r_rhs : r_rhs;
    assign rem_sh    = {r_rem, r_quo[DATA_W-1]};
    assign rem_diff  = rem_sh - {1'b0, r_dvs};
    assign quo_s     = r_neg_q ? -r_quo : r_quo;
    assign rem_s     = r_neg_r ? -r_rem : r_rem;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_in_num  = r_in_num;
        n_err     = r_err;
        n_op      = r_op;
        n_rhs     = r_rhs;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_step    = r_step;
        n_neg_q   = r_neg_q;
        n_neg_r   = r_neg_r;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        push_req  = 1'b0;
        push_val  = r_acc;
        ram_raddr = cnt_m1[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (i_s_axis_tlast) begin
                        n_state = S_END_CLOSE;
                    end else if (r_err == ST_OK) begin
                        if (ch inside {[CH_0:CH_9]}) begin
                            n_acc    = (r_acc << 3) + (r_acc << 1) + digit_val;
                            n_in_num = 1'b1;
                        end else if (ch inside {[CH_TAB:CH_CR], CH_SPACE}) begin
                            push_req = r_in_num;
                            n_in_num = 1'b0;
                            n_acc    = '0;
                        end else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR,
                                                CH_SLASH, CH_PCT}) begin
                            push_req = r_in_num;
                            n_in_num = 1'b0;
                            n_acc    = '0;
                            n_state  = S_OP_RHS;
                            case (ch)
                                CH_PLUS:  n_op = OP_ADD;
                                CH_MINUS: n_op = OP_SUB;
                                CH_STAR:  n_op = OP_MUL;
                                CH_SLASH: n_op = OP_DIV;
                                default:  n_op = OP_MOD;
                            endcase
                        end else begin
                            n_err = ST_INVALID;
                        end
                    end
                end
            end

            S_OP_RHS: begin
                // overflow from closing the number blocks the operator
                if (r_err != ST_OK) begin
                    n_state = S_IDLE;
                end else if (r_cnt < CNT_W'(2)) begin
                    n_err   = ST_UNDERFLOW;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = cnt_m1[ADDR_W-1:0];
                    n_state   = S_OP_LHS;
                end
            end

            S_OP_LHS: begin
                n_rhs     = ram_rdata;
                ram_raddr = cnt_m2[ADDR_W-1:0];
                n_cnt     = cnt_m2;
                n_state   = S_EXEC;
            end

            S_EXEC: begin
                // lhs_cur holds the read issued in S_OP_LHS
                n_state = S_IDLE;
                case (r_op)
                    OP_ADD: begin
                        push_req = 1'b1;
                        push_val = lhs_cur + r_rhs;
                    end
                    OP_SUB: begin
                        push_req = 1'b1;
                        push_val = lhs_cur - r_rhs;
                    end
                    OP_MUL: begin
                        push_req = 1'b1;
                        push_val = mul_lo;
                    end
                    default: begin
                        if (r_rhs == '0) begin
                            n_err = ST_DIVZERO;
                        end else begin
                            n_neg_q = lhs_cur[DATA_W-1] ^ r_rhs[DATA_W-1];
                            n_neg_r = lhs_cur[DATA_W-1];
                            n_quo   = abs_lhs;
                            n_rem   = '0;
                            n_dvs   = abs_rhs;
                            n_step  = '0;
                            n_state = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV: begin
                if (!rem_diff[DATA_W]) begin
                    n_rem = rem_diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == '1) begin
                    n_state = S_DIV_DONE;
                end
            end

            S_DIV_DONE: begin
                push_req = 1'b1;
                push_val = (r_op == OP_DIV) ? quo_s : rem_s;
                n_state  = S_IDLE;
            end

            S_END_CLOSE: begin
                push_req = (r_err == ST_OK) && r_in_num;
                n_in_num = 1'b0;
                n_acc    = '0;
                n_state  = S_END_READ;
            end

            S_END_READ: begin
                ram_raddr = '0;
                n_state   = S_END_OUT;
            end

            S_END_OUT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = '0;
                    if (r_err != ST_OK) begin
                        n_m_user = r_err;
                    end else if (r_cnt == '0) begin
                        n_m_user = ST_EMPTY;
                    end else if (r_cnt > CNT_W'(1)) begin
                        n_m_user = ST_LEFTOVER;
                    end else begin
                        n_m_user = ST_OK;
                        n_m_data = ram_rdata;
                    end
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_in_num = 1'b0;
                    n_err    = ST_OK;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // shared push path: write at the count, or flag a full stack
        ram_we    = 1'b0;
        ram_waddr = r_cnt[ADDR_W-1:0];
        ram_wdata = push_val;
        if (push_req) begin
            if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                n_err = ST_OVERFLOW;
            end else begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_in_num  <= 1'b0;
            r_err     <= ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_in_num  <= n_in_num;
            r_err     <= n_err;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_rhs    <= n_rhs;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_step   <= n_step;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

// ===== src/pfx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the operand stack. No dependencies.
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
